// ===== sv/rts_pkg.sv =====
// Shared types and constants for the rotated texture sampler.
`default_nettype none
package rts_pkg;

  localparam int ACC_W    = 32;
  localparam int STEP_W   = 18;
  localparam int FIELD_W  = 16;
  localparam int COLOUR_W = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_PIXEL = 2'd2
  } op_t;

  localparam logic REG_COS = 1'b0;
  localparam logic REG_SIN = 1'b1;

  localparam logic signed [STEP_W-1:0] COS_RESET = 18'sd65536;
  localparam logic signed [STEP_W-1:0] SIN_RESET = 18'sd0;

  typedef struct packed {
    logic wr;
    logic eol;
    logic eof;
  } cmd_ctl_t;

  localparam int CTL_W = $bits(cmd_ctl_t);

endpackage
`default_nettype wire

// ===== sv/rotated_texture_sampler_top.sv =====
// Rotated texture sampler: a next-pixel transfer passes the command queue, the registered
// texture RAM read and the output buffer register. Throughput is one item per cycle when
// the output is not stalled; the single RAM port serves one write or read a cycle.
// Texel write, start-frame and unused op transfers produce no output transfer.
// Reset (rst_n low, synchronous) clears coordinates, position, queue and output buffer
// and loads the rotation registers; texture contents are undefined until written.
`default_nettype none
module rotated_texture_sampler_top #(
  parameter int TEXTURE_LOG_SIZE = 8,
  parameter int SCREEN_COLUMNS   = 240,
  parameter int SCREEN_ROWS      = 240,
  parameter int FRACTION_BITS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // texel_index[15:0], texel_value[31:16]
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // colour[15:0], sample_index[31:16]
  output logic             out_tlast,  // end_of_line
  output logic             out_tuser,  // end_of_frame
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_addr,
  input  wire logic [17:0] cfg_data
);

  localparam int IDX_W   = 2 * TEXTURE_LOG_SIZE;
  localparam int CW      = rts_pkg::COLOUR_W;
  localparam int Q_W     = rts_pkg::CTL_W + IDX_W + CW;
  localparam int Q_DEPTH = 4;

  logic                 q_push, q_full, q_pop, q_empty;
  rts_pkg::cmd_ctl_t    f_ctl, b_ctl;
  logic [IDX_W-1:0]     f_addr, b_addr, o_idx;
  logic [CW-1:0]        f_data, b_data, o_colour;
  logic [Q_W-1:0]       q_rdata;

  rts_front #(
    .TEXTURE_LOG_SIZE (TEXTURE_LOG_SIZE),
    .SCREEN_COLUMNS   (SCREEN_COLUMNS),
    .SCREEN_ROWS      (SCREEN_ROWS),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_index  (in_tdata[15:0]),
    .in_value  (in_tdata[31:16]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ctl     (f_ctl),
    .q_addr    (f_addr),
    .q_data    (f_data)
  );

  rts_queue #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_ctl, f_addr, f_data}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {b_ctl, b_addr, b_data} = q_rdata;

  rts_back #(
    .TEXTURE_LOG_SIZE (TEXTURE_LOG_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_ctl      (b_ctl),
    .q_addr     (b_addr),
    .q_data     (b_data),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_colour (o_colour),
    .out_idx    (o_idx),
    .out_eol    (out_tlast),
    .out_eof    (out_tuser)
  );

  assign out_tdata = {rts_pkg::FIELD_W'(o_idx), o_colour};

endmodule
`default_nettype wire

// ===== sv/rts_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module rts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/rts_front.sv =====
// Front end: accepts items, holds the rotation registers and walks texture coordinates.
`default_nettype none
module rts_front #(
  parameter int TEXTURE_LOG_SIZE = 8,
  parameter int SCREEN_COLUMNS   = 240,
  parameter int SCREEN_ROWS      = 240,
  parameter int FRACTION_BITS    = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           in_op,
  input  wire logic [rts_pkg::FIELD_W-1:0]          in_index,
  input  wire logic [rts_pkg::COLOUR_W-1:0]         in_value,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic                                 cfg_addr,
  input  wire logic [rts_pkg::STEP_W-1:0]           cfg_data,
  input  wire logic                                 q_full,
  output logic                                      q_push,
  output rts_pkg::cmd_ctl_t                         q_ctl,
  output logic [2*TEXTURE_LOG_SIZE-1:0]             q_addr,
  output logic [rts_pkg::COLOUR_W-1:0]              q_data
);

  localparam int IDX_W = 2 * TEXTURE_LOG_SIZE;
  localparam int COL_W = $clog2(SCREEN_COLUMNS + 1);
  localparam int ROW_W = $clog2(SCREEN_ROWS + 1);
  localparam int ACC_W = rts_pkg::ACC_W;
  localparam int EXT_W = rts_pkg::ACC_W - rts_pkg::STEP_W;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_ROWS - 1);

  logic [rts_pkg::STEP_W-1:0] cos_r, sin_r;
  logic [ACC_W-1:0]           u_r, v_r, ru_r, rv_r;
  logic [ACC_W-1:0]           u_nxt, v_nxt, ru_nxt, rv_nxt;
  logic [COL_W-1:0]           col_r, col_nxt;
  logic [ROW_W-1:0]           row_r, row_nxt;
  logic [ACC_W-1:0]           cos_x, sin_x, u_sh, v_sh;
  logic [IDX_W-1:0]           pix_addr;
  logic                       eol, eof, accept;
  rts_pkg::op_t               op;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign op        = rts_pkg::op_t'(in_op);

  assign cos_x    = {{EXT_W{cos_r[rts_pkg::STEP_W-1]}}, cos_r};
  assign sin_x    = {{EXT_W{sin_r[rts_pkg::STEP_W-1]}}, sin_r};
  assign u_sh     = u_r >> FRACTION_BITS;
  assign v_sh     = v_r >> FRACTION_BITS;
  assign pix_addr = {v_sh[TEXTURE_LOG_SIZE-1:0], u_sh[TEXTURE_LOG_SIZE-1:0]};
  assign eol      = (col_r == COL_LAST);
  assign eof      = eol && (row_r == ROW_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= rts_pkg::COS_RESET;
      sin_r <= rts_pkg::SIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        rts_pkg::REG_COS: cos_r <= cfg_data;
        rts_pkg::REG_SIN: sin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    u_nxt   = u_r;
    v_nxt   = v_r;
    ru_nxt  = ru_r;
    rv_nxt  = rv_r;
    col_nxt = col_r;
    row_nxt = row_r;
    q_push  = 1'b0;
    q_ctl   = '0;
    q_addr  = pix_addr;
    q_data  = in_value;
    if (accept) begin
      case (op)
        rts_pkg::OP_WRITE: begin
          q_push   = 1'b1;
          q_ctl.wr = 1'b1;
          q_addr   = IDX_W'(in_index);
        end
        rts_pkg::OP_START: begin
          u_nxt   = '0;
          v_nxt   = '0;
          ru_nxt  = '0;
          rv_nxt  = '0;
          col_nxt = '0;
          row_nxt = '0;
        end
        rts_pkg::OP_PIXEL: begin
          q_push    = 1'b1;
          q_ctl.eol = eol;
          q_ctl.eof = eof;
          if (eof) begin
            u_nxt   = '0;
            v_nxt   = '0;
            ru_nxt  = '0;
            rv_nxt  = '0;
            col_nxt = '0;
            row_nxt = '0;
          end else if (eol) begin
            ru_nxt  = ru_r - sin_x;
            rv_nxt  = rv_r + cos_x;
            u_nxt   = ru_r - sin_x;
            v_nxt   = rv_r + cos_x;
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            u_nxt   = u_r + cos_x;
            v_nxt   = v_r + sin_x;
            col_nxt = col_r + COL_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r   <= '0;
      v_r   <= '0;
      ru_r  <= '0;
      rv_r  <= '0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      u_r   <= u_nxt;
      v_r   <= v_nxt;
      ru_r  <= ru_nxt;
      rv_r  <= rv_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rts_queue.sv =====
// Small command FIFO between front and back end.
`default_nettype none
module rts_queue #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r, wr_nxt, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rts_back.sv =====
// Back end: texture RAM access and a two-entry output buffer.
`default_nettype none
module rts_back #(
  parameter int TEXTURE_LOG_SIZE = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 q_empty,
  input  wire rts_pkg::cmd_ctl_t                    q_ctl,
  input  wire logic [2*TEXTURE_LOG_SIZE-1:0]        q_addr,
  input  wire logic [rts_pkg::COLOUR_W-1:0]         q_data,
  output logic                                      q_pop,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [rts_pkg::COLOUR_W-1:0]              out_colour,
  output logic [2*TEXTURE_LOG_SIZE-1:0]             out_idx,
  output logic                                      out_eol,
  output logic                                      out_eof
);

  localparam int IDX_W = 2 * TEXTURE_LOG_SIZE;
  localparam int CW    = rts_pkg::COLOUR_W;

  logic [CW-1:0]    rdata;
  logic             s1_valid_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_eol_r, s1_eof_r;
  logic [CW-1:0]    ob_colour_r [2];
  logic [IDX_W-1:0] ob_idx_r [2];
  logic [1:0]       ob_eol_r, ob_eof_r;
  logic             ob_wr_r, ob_rd_r;
  logic [1:0]       ob_cnt_r, ob_cnt_nxt;
  logic [2:0]       inflight;
  logic             pop_out, read_ok;

  assign out_valid = (ob_cnt_r != 2'd0);
  assign pop_out   = out_valid && out_ready;
  assign inflight  = {1'b0, ob_cnt_r} + {2'b00, s1_valid_r} - {2'b00, pop_out};
  assign read_ok   = (inflight < 3'd2);
  assign q_pop     = !q_empty && (q_ctl.wr || read_ok);

  rts_ram #(
    .WIDTH (CW),
    .DEPTH (1 << IDX_W)
  ) u_tex (
    .clk   (clk),
    .we    (q_pop && q_ctl.wr),
    .addr  (q_addr),
    .wdata (q_data),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= q_pop && !q_ctl.wr;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= q_addr;
    s1_eol_r <= q_ctl.eol;
    s1_eof_r <= q_ctl.eof;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      ob_colour_r[ob_wr_r] <= rdata;
      ob_idx_r[ob_wr_r]    <= s1_idx_r;
      ob_eol_r[ob_wr_r]    <= s1_eol_r;
      ob_eof_r[ob_wr_r]    <= s1_eof_r;
    end
  end

  always_comb begin
    ob_cnt_nxt = ob_cnt_r;
    if (s1_valid_r && !pop_out) begin
      ob_cnt_nxt = ob_cnt_r + 2'd1;
    end else if (pop_out && !s1_valid_r) begin
      ob_cnt_nxt = ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      ob_cnt_r <= ob_cnt_nxt;
      if (s1_valid_r) begin
        ob_wr_r <= !ob_wr_r;
      end
      if (pop_out) begin
        ob_rd_r <= !ob_rd_r;
      end
    end
  end

  assign out_colour = ob_colour_r[ob_rd_r];
  assign out_idx    = ob_idx_r[ob_rd_r];
  assign out_eol    = ob_eol_r[ob_rd_r];
  assign out_eof    = ob_eof_r[ob_rd_r];

endmodule
`default_nettype wire

// ===== sv/rts_checker.sv =====
// Port-level checker for the rotated texture sampler, bound to the top level.
`default_nettype none
module rts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_eof_is_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("end of frame without end of line");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output transfer changed while stalled");

endmodule

bind rotated_texture_sampler_top rts_checker u_rts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the rotated texture sampler: directed table, line sweep, random phases.
module tb;

  localparam int FRAC         = 16;
  localparam int TEX_LOG      = 8;
  localparam int COLS         = 240;
  localparam int ROWS         = 240;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 155;
  localparam int SWEEP_PIXELS = 2 * COLS + 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 8;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int REPORT_MAX   = 50;

  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam logic [17:0] STEP_ONE       = 18'h10000;
  localparam logic [17:0] STEP_MINUS_ONE = 18'h30000;
  localparam logic [17:0] STEP_HALF      = 18'h08000;
  localparam logic [17:0] STEP_ZERO      = 18'h00000;

  typedef struct packed {
    logic [15:0] colour;
    logic [15:0] index;
    logic        eol;
    logic        eof;
  } pixel_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  op;
    logic [15:0] idx;
    logic [15:0] val;
    logic [17:0] cos_s;
    logic [17:0] sin_s;
    logic        typed;
    pixel_t      want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // texel_index[15:0], texel_value[31:16]
  logic [1:0]  in_tuser;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // colour[15:0], sample_index[31:16]
  logic        out_tlast;  // end_of_line
  logic        out_tuser;  // end_of_frame
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_addr;
  logic [17:0] cfg_data;

  rotated_texture_sampler_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // predictor state
  logic [15:0] tex_mem [0:65535];
  bit          tex_valid [0:65535];
  logic [31:0] u_acc, v_acc, u_row, v_row, cos_sx, sin_sx;
  int          col, row;
  pixel_t      pixel_q [$];

  int fail_count, cycles, burst_left, n_holds;
  int n_items, n_pixels, n_writes, n_starts, n_unused, n_eol, n_eof, n_settings;
  bit hold_pending;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pixel_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] next_sample();
    return {v_acc[FRAC +: TEX_LOG], u_acc[FRAC +: TEX_LOG]};
  endfunction

  function automatic logic [31:0] widen(input logic [17:0] s);
    return {{14{s[17]}}, s};
  endfunction

  function automatic logic [17:0] pick_step();
    int s;
    case ($urandom_range(3))
      0: s = 65536;
      1: s = -65536;
      2: s = int'($urandom_range(4095)) - 2048;
      default: s = int'($urandom_range(131072)) - 65536;
    endcase
    return s[17:0];
  endfunction

  function automatic row_t item_row(input logic [1:0] op, input logic [15:0] idx, val);
    row_t r;
    r = '0;
    r.op = op;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic row_t pixel_row(input logic [15:0] colour, index);
    row_t r;
    r = '0;
    r.op = rts_pkg::OP_PIXEL;
    r.typed = 1'b1;
    r.want.colour = colour;
    r.want.index = index;
    return r;
  endfunction

  function automatic row_t steps_row(input logic [17:0] c, s);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cos_s = c;
    r.sin_s = s;
    return r;
  endfunction

  task automatic clear_frame();
    u_acc = '0;
    v_acc = '0;
    u_row = '0;
    v_row = '0;
    col = 0;
    row = 0;
  endtask

  task automatic sample_step(input logic [1:0] op, input logic [15:0] idx, val,
                             output bit hit, output pixel_t px);
    hit = 1'b0;
    px = '0;
    case (op)
      rts_pkg::OP_WRITE: begin
        tex_mem[idx] = val;
        tex_valid[idx] = 1'b1;
        n_writes++;
      end
      rts_pkg::OP_START: begin
        clear_frame();
        n_starts++;
      end
      rts_pkg::OP_PIXEL: begin
        hit = 1'b1;
        px.index = next_sample();
        px.colour = tex_mem[px.index];
        px.eol = (col >= COLS - 1);
        px.eof = px.eol && (row >= ROWS - 1);
        n_pixels++;
        n_eol += px.eol;
        n_eof += px.eof;
        if (px.eof) begin
          clear_frame();
        end else if (px.eol) begin
          u_row = u_row - sin_sx;
          v_row = v_row + cos_sx;
          u_acc = u_row;
          v_acc = v_row;
          col = 0;
          row++;
        end else begin
          u_acc = u_acc + cos_sx;
          v_acc = v_acc + sin_sx;
          col++;
        end
      end
      default: n_unused++;
    endcase
  endtask

  task automatic push_item(input logic [1:0] op, input logic [15:0] idx, val,
                           input bit typed, input pixel_t want);
    bit     hit;
    pixel_t px;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {val, idx};
    do @(posedge clk); while (!in_tready);
    sample_step(op, idx, val, hit, px);
    if (hit) pixel_q.push_back(typed ? want : px);
    if (op != OP_UNUSED) n_items++;
  endtask

  // sender paces itself in bursts separated by short gaps
  task automatic offer(input logic [1:0] op, input logic [15:0] idx, val,
                       input bit typed, input pixel_t want);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = ($urandom_range(9) == 0) ? 300 : $urandom_range(40, 1);
    end
    burst_left--;
    push_item(op, idx, val, typed, want);
  endtask

  // never sample an entry that has not been written
  task automatic offer_pixel();
    logic [15:0] at;
    at = next_sample();
    if (!tex_valid[at]) offer(rts_pkg::OP_WRITE, at, 16'($urandom), 1'b0, '0);
    offer(rts_pkg::OP_PIXEL, 16'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pixel_q.size() != 0);
  endtask

  task automatic set_steps(input logic [17:0] c, s);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= rts_pkg::REG_COS;
    cfg_data <= c;
    do @(posedge clk); while (!cfg_ready);
    cos_sx = widen(c);
    cfg_addr <= rts_pkg::REG_SIN;
    cfg_data <= s;
    do @(posedge clk); while (!cfg_ready);
    sin_sx = widen(s);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic flag(input string what, input int exp_v, got_v);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $error("%s mismatch: expected 0x%0h, got 0x%0h", what, exp_v, got_v);
  endtask

  always @(posedge clk) begin : result_check
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $error("unexpected result transfer: data 0x%0h", out_tdata);
      end else begin
        want = pixel_q.pop_front();
        if (out_tdata[15:0] !== want.colour) flag("colour", want.colour, out_tdata[15:0]);
        if (out_tdata[31:16] !== want.index)
          flag("sample_index", want.index, out_tdata[31:16]);
        if (out_tlast !== want.eol) flag("end_of_line", want.eol, out_tlast);
        if (out_tuser !== want.eof) flag("end_of_frame", want.eof, out_tuser);
      end
    end
  end

  // receiver: random stall patterns, plus one long hold-off on request
  initial begin : rx_pace
    int mode, seg;
    seg = 0;
    mode = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        n_holds++;
      end
      if (seg == 0) begin
        mode = $urandom_range(2);
        seg = $urandom_range(200, 20);
      end
      seg--;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(3) != 0);
        default: out_tready <= ($urandom_range(99) < 35);
      endcase
    end
  end

  initial begin : stimulus
    row_t tab [$];
    row_t r;
    int   ph, k, sel, first;
    bit   paused;

    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_valid <= 1'b0;
    cfg_addr <= rts_pkg::REG_COS;
    cfg_data <= '0;
    rst_n <= 1'b0;
    hold_pending = 1'b0;
    burst_left = 0;
    paused = 1'b0;
    cos_sx = widen(rts_pkg::COS_RESET);
    sin_sx = widen(rts_pkg::SIN_RESET);
    clear_frame();

    tab.push_back(item_row(rts_pkg::OP_WRITE, 16'h0000, 16'hFFFF));
    tab.push_back(item_row(rts_pkg::OP_WRITE, 16'h0001, 16'h0000));
    tab.push_back(item_row(rts_pkg::OP_WRITE, 16'h0002, 16'h5A5A));
    tab.push_back(item_row(rts_pkg::OP_WRITE, 16'hFFFF, 16'hA5A5));
    tab.push_back(item_row(rts_pkg::OP_WRITE, 16'h0101, 16'h0F0F));
    tab.push_back(pixel_row(16'hFFFF, 16'h0000));
    tab.push_back(pixel_row(16'h0000, 16'h0001));
    tab.push_back(pixel_row(16'h5A5A, 16'h0002));
    tab.push_back(item_row(OP_UNUSED, 16'hFFFF, 16'hFFFF));
    tab.push_back(item_row(rts_pkg::OP_START, 16'hFFFF, 16'hFFFF));
    tab.push_back(pixel_row(16'hFFFF, 16'h0000));
    // negative extremes: second pixel wraps to the far corner
    tab.push_back(steps_row(STEP_MINUS_ONE, STEP_MINUS_ONE));
    tab.push_back(item_row(rts_pkg::OP_START, 16'h0000, 16'h0000));
    tab.push_back(pixel_row(16'hFFFF, 16'h0000));
    tab.push_back(pixel_row(16'hA5A5, 16'hFFFF));
    tab.push_back(steps_row(STEP_ONE, STEP_ONE));
    tab.push_back(item_row(rts_pkg::OP_START, 16'h0000, 16'h0000));
    tab.push_back(pixel_row(16'hFFFF, 16'h0000));
    tab.push_back(pixel_row(16'h0F0F, 16'h0101));
    // half step: fractional part must be dropped
    tab.push_back(steps_row(STEP_HALF, STEP_ZERO));
    tab.push_back(item_row(rts_pkg::OP_START, 16'h0000, 16'h0000));
    for (k = 0; k < 4; k++) tab.push_back(item_row(rts_pkg::OP_PIXEL, 16'h0000, 16'h0000));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (tab[i]) begin
      r = tab[i];
      if (r.is_cfg) set_steps(r.cos_s, r.sin_s);
      else offer(r.op, r.idx, r.val, r.typed, r.want);
    end

    // two full rows and a bit: line ends and row start stepping
    set_steps(18'(1000), 18'(-600));
    offer(rts_pkg::OP_START, 16'($urandom), 16'($urandom), 1'b0, '0);
    for (k = 0; k < SWEEP_PIXELS; k++) offer_pixel();

    for (ph = 0; ph < PHASES; ph++) begin
      set_steps(pick_step(), pick_step());
      if (ph == 1) begin
        hold_pending = 1'b1;
        burst_left = 2 * HOLD_CYCLES;
      end
      first = n_items;
      while (n_items - first < PHASE_ITEMS) begin
        if (ph == 3 && !paused && n_items - first >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          wait_idle();
        end
        sel = $urandom_range(99);
        if (sel < 70) offer_pixel();
        else if (sel < 85)
          offer(rts_pkg::OP_WRITE, 16'($urandom), 16'($urandom), 1'b0, '0);
        else if (sel < 90)
          offer(rts_pkg::OP_START, 16'($urandom), 16'($urandom), 1'b0, '0);
        else if (sel < 95) offer(OP_UNUSED, 16'($urandom), 16'($urandom), 1'b0, '0);
        else repeat (8) offer_pixel();
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run: %0d items, %0d pixels (%0d line ends, %0d frame ends), %0d texel writes,",
             n_items, n_pixels, n_eol, n_eof, n_writes);
    $display("     %0d frame starts, %0d unused ops, %0d step settings, %0d long stalls",
             n_starts, n_unused, n_settings, n_holds);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
